// ----- rtl/cbm_pkg.sv -----
// Shared types, widths and character codes for the brace matcher.
// No dependencies; every other file imports this package.
package cbm_pkg;

    // Width of the byte position counter and of the brace depth counter
    localparam int OFFSET_BITS = 16;
    localparam int DEPTH_BITS  = 16;

    // Width of the offset field in a result
    localparam int MATCH_W     = 16;

    // Character codes recognized by the lexer
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;

    // Lexical mode, one-hot
    typedef enum logic [6:0] {
        LEX_NORMAL = 7'b0000001,
        LEX_SLASH  = 7'b0000010,
        LEX_LINE   = 7'b0000100,
        LEX_BLOCK  = 7'b0001000,
        LEX_STAR   = 7'b0010000,
        LEX_STR    = 7'b0100000,
        LEX_ESC    = 7'b1000000
    } lex_mode_t;

    // Scan state carried from one byte to the next
    typedef struct packed {
        lex_mode_t              mode;
        logic                   quote_single;
        logic [DEPTH_BITS-1:0]  depth;
        logic [OFFSET_BITS-1:0] pos;
        logic                   done;
    } scan_state_t;

    // Result produced by one byte, if any
    typedef struct packed {
        logic               valid;
        logic               found;
        logic [MATCH_W-1:0] offset;
    } scan_result_t;

    localparam scan_state_t SCAN_CLEAR = '{
        mode:         LEX_NORMAL,
        quote_single: 1'b0,
        depth:        '0,
        pos:          '0,
        done:         1'b0
    };

endpackage

// ----- rtl/cbm_lex.sv -----
// Next-state function of the brace matcher: lexical mode, depth, position.
// Depends on cbm_pkg.
module cbm_lex
    import cbm_pkg::*;
(
    input  scan_state_t  cur,
    input  logic [7:0]   char_byte,
    input  logic         scan_start,
    input  logic         scan_last,
    output scan_state_t  nxt,
    output scan_result_t res
);

    scan_state_t st;
    logic        do_normal;
    logic        hit;
    logic [7:0]  quote_ch;
    logic [31:0] pos_wide;

    // Clear the state on a new scan before the byte is looked at
    assign st       = scan_start ? SCAN_CLEAR : cur;
    assign quote_ch = st.quote_single ? CH_SQUOTE : CH_DQUOTE;
    assign pos_wide = 32'(st.pos);

    always_comb
    begin
        nxt       = st;
        res       = '0;
        do_normal = 1'b0;
        hit       = 1'b0;

        if (!st.done)
        begin
            // Advance the lexical mode
            case (st.mode)
                LEX_SLASH:
                begin
                    if (char_byte == CH_SLASH)
                        nxt.mode = LEX_LINE;
                    else if (char_byte == CH_STAR)
                        nxt.mode = LEX_BLOCK;
                    else
                    begin
                        nxt.mode  = LEX_NORMAL;
                        do_normal = 1'b1;
                    end
                end
                LEX_LINE:
                begin
                    if (char_byte == CH_NEWLINE)
                        nxt.mode = LEX_NORMAL;
                end
                LEX_BLOCK:
                begin
                    if (char_byte == CH_STAR)
                        nxt.mode = LEX_STAR;
                end
                LEX_STAR:
                begin
                    if (char_byte == CH_SLASH)
                        nxt.mode = LEX_NORMAL;
                    else if (char_byte != CH_STAR)
                        nxt.mode = LEX_BLOCK;
                end
                LEX_STR:
                begin
                    if (char_byte == CH_BACKSLASH)
                        nxt.mode = LEX_ESC;
                    else if (char_byte == quote_ch)
                        nxt.mode = LEX_NORMAL;
                end
                LEX_ESC:
                begin
                    nxt.mode = LEX_STR;
                end
                default:
                begin
                    nxt.mode  = LEX_NORMAL;
                    do_normal = 1'b1;
                end
            endcase

            // Handle a byte seen in normal code
            if (do_normal)
            begin
                if (char_byte == CH_SLASH)
                    nxt.mode = LEX_SLASH;
                else if (char_byte == CH_DQUOTE || char_byte == CH_SQUOTE)
                begin
                    nxt.mode         = LEX_STR;
                    nxt.quote_single = (char_byte == CH_SQUOTE);
                end
                else if (char_byte == CH_LBRACE)
                begin
                    if (st.depth != '1)
                        nxt.depth = st.depth + 1'b1;
                end
                else if (char_byte == CH_RBRACE)
                begin
                    if (st.depth != '0)
                    begin
                        nxt.depth = st.depth - 1'b1;
                        hit       = (st.depth == DEPTH_BITS'(1));
                    end
                end
            end

            // Report a match, or advance the position and close on the last byte
            if (hit)
            begin
                res.valid  = 1'b1;
                res.found  = 1'b1;
                res.offset = pos_wide[MATCH_W-1:0];
                nxt.done   = 1'b1;
            end
            else
            begin
                if (st.pos != '1)
                    nxt.pos = st.pos + 1'b1;
                if (scan_last)
                begin
                    res.valid = 1'b1;
                    nxt.done  = 1'b1;
                end
            end
        end
    end

endmodule

// ----- rtl/cbm_out.sv -----
// Output register of the brace matcher, holding one result until taken.
// Depends on cbm_pkg.
module cbm_out
    import cbm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  scan_result_t       res,
    input  logic               m_axis_tready,
    output logic               m_axis_tvalid,
    output logic [MATCH_W-1:0] m_axis_tdata,
    output logic               m_axis_tuser
);

    logic               valid_reg;
    logic               valid_next;
    logic               found_reg;
    logic [MATCH_W-1:0] offset_reg;
    logic               take;

    assign take       = load && res.valid;
    assign valid_next = (valid_reg && !m_axis_tready) || take;

    // Track whether a result is waiting
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            found_reg  <= res.found;
            offset_reg <= res.offset;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = offset_reg;
    assign m_axis_tuser  = found_reg;

endmodule

// ----- rtl/c_brace_matcher.sv -----
// Top level of the C brace matcher: scan state register, lexer, output register.
// Depends on cbm_pkg, cbm_lex and cbm_out.
//
//  channel   dir  tdata (low bit up)        tuser        tlast
//  s_axis    in   char_byte[7:0]            scan_start   scan_last
//  m_axis    out  match_offset[15:0]        found        -
//
// One byte per cycle unless stalled; a result appears on m_axis the cycle after
// its byte is taken. The byte's whole lexer step is combinational from the scan
// state register. s_axis_tready drops only while a result waits on m_axis and
// m_axis_tready is low. Reset clears the scan state as if a scan had begun.
module c_brace_matcher
    import cbm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,  // char_byte[7:0]
    input  logic               s_axis_tuser,  // scan_start
    input  logic               s_axis_tlast,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [MATCH_W-1:0] m_axis_tdata,  // match_offset[15:0]
    output logic               m_axis_tuser   // found
);

    scan_state_t  state_reg;
    scan_state_t  state_next;
    scan_result_t res;
    logic         accept;

    // Take a byte whenever the output slot is free or being drained
    assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    cbm_lex u_lex (
        .cur        (state_reg),
        .char_byte  (s_axis_tdata),
        .scan_start (s_axis_tuser),
        .scan_last  (s_axis_tlast),
        .nxt        (state_next),
        .res        (res)
    );

    // Hold the scan state between requests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= SCAN_CLEAR;
        else if (accept)
            state_reg <= state_next;
    end

    cbm_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (accept),
        .res           (res),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ----- rtl/cbm_checker.sv -----
// Port-level checks for the C brace matcher, bound to the top level.
// Depends on cbm_pkg and c_brace_matcher.
module cbm_checker
    import cbm_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [MATCH_W-1:0] m_axis_tdata,
    input logic               m_axis_tuser
);

    // A pending result stays up while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result payload changed while stalled");

    // Input stalls only behind a blocked result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a blocked result");

    // An unmatched result carries a zero offset
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("not-found result with nonzero offset");

    // A new result follows an accepted request
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("result without an accepted request");

endmodule

bind c_brace_matcher cbm_checker u_cbm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for c_brace_matcher: byte requests stream in on s_axis,
// match and no-match results are checked on m_axis against a built-in lexer model.
// Depends on cbm_pkg and the c_brace_matcher RTL.
module testbench
    import cbm_pkg::*;
();

    // Directed row kinds: check against the model, or against a typed result
    typedef enum logic [1:0] {
        ROW_PREDICT   = 2'd0,
        ROW_NO_RESULT = 2'd1,
        ROW_RESULT    = 2'd2
    } row_kind_t;

    typedef struct packed {
        logic               found;
        logic [MATCH_W-1:0] offset;
    } brace_result_t;

    typedef struct packed {
        logic [7:0]    ch;
        logic          start;
        logic          last;
        row_kind_t     kind;
        brace_result_t typed;
    } stim_row_t;

    localparam int STIM_ROWS = 29;
    localparam int RAND_PER_PHASE = 310;
    localparam int HOLD_CYCLES = 400;
    localparam int NEST_DEPTH = 24;

    localparam stim_row_t STIM_TABLE [STIM_ROWS] = '{
        // bytes before any scan start behave as a scan from offset 0
        '{CH_LBRACE,    1'b0, 1'b0, ROW_PREDICT,   '{1'b0, 16'd0}},
        '{CH_RBRACE,    1'b0, 1'b0, ROW_RESULT,    '{1'b1, 16'd1}},
        // finished scan ignores bytes, even with the last flag
        '{CH_RBRACE,    1'b0, 1'b1, ROW_NO_RESULT, '{1'b0, 16'd0}},
        // close brace at depth zero is dropped
        '{CH_RBRACE,    1'b1, 1'b0, ROW_NO_RESULT, '{1'b0, 16'd0}},
        '{8'h00,        1'b0, 1'b0, ROW_NO_RESULT, '{1'b0, 16'd0}},
        '{8'hFF,        1'b0, 1'b1, ROW_RESULT,    '{1'b0, 16'd0}},
        // lone slash, then a brace in normal mode
        '{CH_LBRACE,    1'b1, 1'b0, ROW_PREDICT,   '{1'b0, 16'd0}},
        '{CH_SLASH,     1'b0, 1'b0, ROW_PREDICT,   '{1'b0, 16'd0}},
        '{CH_LBRACE,    1'b0, 1'b0, ROW_PREDICT,   '{1'b0, 16'd0}},
        // line comment hides a brace until newline
        '{CH_SLASH,     1'b0, 1'b0, ROW_PREDICT,   '{1'b0, 16'd0}},
        '{CH_SLASH,     1'b0, 1'b0, ROW_PREDICT,   '{1'b0, 16'd0}},
        '{CH_RBRACE,    1'b0, 1'b0, ROW_PREDICT,   '{1'b0, 16'd0}},
        '{CH_NEWLINE,   1'b0, 1'b0, ROW_PREDICT,   '{1'b0, 16'd0}},
        // block comment with a star followed by a brace
        '{CH_SLASH,     1'b0, 1'b0, ROW_PREDICT,   '{1'b0, 16'd0}},
        '{CH_STAR,      1'b0, 1'b0, ROW_PREDICT,   '{1'b0, 16'd0}},
        '{CH_STAR,      1'b0, 1'b0, ROW_PREDICT,   '{1'b0, 16'd0}},
        '{CH_RBRACE,    1'b0, 1'b0, ROW_PREDICT,   '{1'b0, 16'd0}},
        '{CH_STAR,      1'b0, 1'b0, ROW_PREDICT,   '{1'b0, 16'd0}},
        '{CH_SLASH,     1'b0, 1'b0, ROW_PREDICT,   '{1'b0, 16'd0}},
        // string with an escaped quote and the other quote inside
        '{CH_DQUOTE,    1'b0, 1'b0, ROW_PREDICT,   '{1'b0, 16'd0}},
        '{CH_BACKSLASH, 1'b0, 1'b0, ROW_PREDICT,   '{1'b0, 16'd0}},
        '{CH_DQUOTE,    1'b0, 1'b0, ROW_PREDICT,   '{1'b0, 16'd0}},
        '{CH_SQUOTE,    1'b0, 1'b0, ROW_PREDICT,   '{1'b0, 16'd0}},
        '{CH_DQUOTE,    1'b0, 1'b0, ROW_PREDICT,   '{1'b0, 16'd0}},
        // character literal holding a brace
        '{CH_SQUOTE,    1'b0, 1'b0, ROW_PREDICT,   '{1'b0, 16'd0}},
        '{CH_RBRACE,    1'b0, 1'b0, ROW_PREDICT,   '{1'b0, 16'd0}},
        '{CH_SQUOTE,    1'b0, 1'b0, ROW_PREDICT,   '{1'b0, 16'd0}},
        // match on the last byte
        '{CH_RBRACE,    1'b0, 1'b0, ROW_PREDICT,   '{1'b0, 16'd0}},
        '{CH_RBRACE,    1'b0, 1'b1, ROW_PREDICT,   '{1'b0, 16'd0}}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = 8'h00;  // char_byte[7:0]
    logic               s_axis_tuser = 1'b0;   // scan_start
    logic               s_axis_tlast = 1'b0;   // scan_last
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [MATCH_W-1:0] m_axis_tdata;          // match_offset[15:0]
    logic               m_axis_tuser;          // found

    // Lexer model state
    lex_mode_t              lx_mode = LEX_NORMAL;
    logic                   lx_quote_single = 1'b0;
    logic [DEPTH_BITS-1:0]  lx_depth = '0;
    logic [OFFSET_BITS-1:0] lx_pos = '0;
    logic                   lx_done = 1'b0;

    brace_result_t pending_matches [$];

    int err_count = 0;
    int live_bytes = 0;
    int scan_count = 0;
    int match_count = 0;
    int miss_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    c_brace_matcher dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Normal-mode byte; returns 1 when the depth falls back to zero
    function automatic logic take_normal(input logic [7:0] ch);
        logic hit;
        hit = 1'b0;
        if (ch == CH_SLASH)
            lx_mode = LEX_SLASH;
        else if (ch == CH_DQUOTE || ch == CH_SQUOTE)
        begin
            lx_mode = LEX_STR;
            lx_quote_single = (ch == CH_SQUOTE);
        end
        else if (ch == CH_LBRACE)
        begin
            if (lx_depth != '1)
                lx_depth = lx_depth + 1'b1;
        end
        else if (ch == CH_RBRACE && lx_depth != '0)
        begin
            lx_depth = lx_depth - 1'b1;
            hit = (lx_depth == '0);
        end
        return hit;
    endfunction

    // Advance the lexer by one byte; emit is set when the byte yields a result
    function automatic void predict_match(input logic [7:0] ch, input logic start,
                                          input logic last, output logic emit,
                                          output brace_result_t res);
        logic [7:0] quote_ch;
        logic       hit;
        emit = 1'b0;
        res = '0;
        hit = 1'b0;
        if (start)
        begin
            lx_mode = LEX_NORMAL;
            lx_quote_single = 1'b0;
            lx_depth = '0;
            lx_pos = '0;
            lx_done = 1'b0;
            scan_count++;
        end
        if (lx_done)
            return;
        live_bytes++;
        quote_ch = lx_quote_single ? CH_SQUOTE : CH_DQUOTE;
        case (lx_mode)
            LEX_SLASH:
                if (ch == CH_SLASH)
                    lx_mode = LEX_LINE;
                else if (ch == CH_STAR)
                    lx_mode = LEX_BLOCK;
                else
                begin
                    lx_mode = LEX_NORMAL;
                    hit = take_normal(ch);
                end
            LEX_LINE:
                if (ch == CH_NEWLINE)
                    lx_mode = LEX_NORMAL;
            LEX_BLOCK:
                if (ch == CH_STAR)
                    lx_mode = LEX_STAR;
            LEX_STAR:
                if (ch == CH_SLASH)
                    lx_mode = LEX_NORMAL;
                else if (ch != CH_STAR)
                    lx_mode = LEX_BLOCK;
            LEX_STR:
                if (ch == CH_BACKSLASH)
                    lx_mode = LEX_ESC;
                else if (ch == quote_ch)
                    lx_mode = LEX_NORMAL;
            LEX_ESC:
                lx_mode = LEX_STR;
            default:
            begin
                lx_mode = LEX_NORMAL;
                hit = take_normal(ch);
            end
        endcase
        if (hit)
        begin
            emit = 1'b1;
            res.found = 1'b1;
            res.offset = lx_pos;
            lx_done = 1'b1;
            match_count++;
            return;
        end
        if (lx_pos != '1)
            lx_pos = lx_pos + 1'b1;
        if (last)
        begin
            emit = 1'b1;
            lx_done = 1'b1;
            miss_count++;
        end
    endfunction

    // Weighted pick of source-like bytes
    function automatic logic [7:0] pick_c_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 14) return CH_LBRACE;
        if (r < 32) return CH_RBRACE;
        if (r < 40) return CH_SLASH;
        if (r < 47) return CH_STAR;
        if (r < 53) return CH_DQUOTE;
        if (r < 58) return CH_SQUOTE;
        if (r < 63) return CH_BACKSLASH;
        if (r < 69) return CH_NEWLINE;
        if (r < 88) return 8'(8'h61 + $urandom_range(0, 25));
        return 8'($urandom_range(0, 255));
    endfunction

    // Offer one request, wait for the handshake, then record what it should yield
    task automatic push_byte(input logic [7:0] ch, input logic start, input logic last,
                             input row_kind_t kind, input brace_result_t typed);
        logic          emit;
        brace_result_t res;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tuser  <= start;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_match(ch, start, last, emit, res);
        case (kind)
            ROW_RESULT:
                pending_matches.push_back(typed);
            ROW_NO_RESULT:
                ;
            default:
                if (emit)
                    pending_matches.push_back(res);
        endcase
    endtask

    // Hold the sender until every expected result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly well-formed scans with random content, some broken scans and noise
    task automatic random_phase(input int target);
        int first_live;
        int len;
        int r;
        logic [7:0] ch;
        logic start;
        first_live = live_bytes;
        while (live_bytes - first_live < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 82)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 160)
                                                  : $urandom_range(2, 40);
                for (int i = 0; i < len; i++)
                begin
                    start = (i == 0) ? ($urandom_range(0, 19) != 0)
                                     : ($urandom_range(0, 99) == 0);
                    ch = (i == 0 && $urandom_range(0, 9) != 0) ? CH_LBRACE : pick_c_byte();
                    push_byte(ch, start,
                              (i == len - 1) && ($urandom_range(0, 4) != 0),
                              ROW_PREDICT, '0);
                    if (lx_done)
                        break;
                end
            end
            else
            begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                    push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0,
                              $urandom_range(0, 3) == 0, ROW_PREDICT, '0);
            end
        end
    endtask

    // Receiver: check accepted results, then pick next ready
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_matches.size() == 0)
            begin
                $error("unexpected result: found=%0b match_offset=%0d",
                       m_axis_tuser, m_axis_tdata);
                err_count++;
            end
            else
            begin
                if (m_axis_tuser !== pending_matches[0].found)
                begin
                    $error("found: expected %0b, actual %0b",
                           pending_matches[0].found, m_axis_tuser);
                    err_count++;
                end
                if (m_axis_tdata !== pending_matches[0].offset)
                begin
                    $error("match_offset: expected %0d, actual %0d",
                           pending_matches[0].offset, m_axis_tdata);
                    err_count++;
                end
                void'(pending_matches.pop_front());
            end
        end
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    initial
    begin
        tx_idle_pct <= 24;
        rx_idle_pct <= 57;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (int i = 0; i < STIM_ROWS; i++)
            push_byte(STIM_TABLE[i].ch, STIM_TABLE[i].start, STIM_TABLE[i].last,
                      STIM_TABLE[i].kind, STIM_TABLE[i].typed);
        drain_results();

        // Phase one: sender idles a little, receiver a lot
        random_phase(RAND_PER_PHASE);
        drain_results();

        // Stall the receiver while short matching scans keep coming
        tx_idle_pct <= 0;
        hold_req <= hold_req + 1;
        for (int i = 0; i < 30; i++)
        begin
            push_byte(CH_LBRACE, 1'b1, 1'b0, ROW_PREDICT, '0);
            push_byte(CH_RBRACE, 1'b0, 1'b0, ROW_PREDICT, '0);
        end
        drain_results();

        // Phase two: the other way round
        tx_idle_pct <= 57;
        rx_idle_pct <= 24;
        random_phase(RAND_PER_PHASE);
        drain_results();

        // Phase three: no idling on either side
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        random_phase(RAND_PER_PHASE);

        // Nest braces deeply, then close every one of them
        push_byte(CH_LBRACE, 1'b1, 1'b0, ROW_PREDICT, '0);
        for (int i = 0; i < NEST_DEPTH; i++)
            push_byte(CH_LBRACE, 1'b0, 1'b0, ROW_PREDICT, '0);
        for (int i = 0; i <= NEST_DEPTH; i++)
            push_byte(CH_RBRACE, 1'b0, 1'b0, ROW_PREDICT, '0);
        drain_results();
        repeat (8) @(posedge clk);

        $display("Run covered %0d live bytes over %0d scans, all lexer modes and idle mixes;",
                 live_bytes, scan_count);
        $display("%0d matches and %0d unmatched ranges checked, %0d errors.",
                 match_count, miss_count, err_count);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Run limit
    initial
    begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- c_brace_matcher.f -----
rtl/cbm_pkg.sv
rtl/cbm_lex.sv
rtl/cbm_out.sv
rtl/c_brace_matcher.sv
rtl/cbm_checker.sv
tb/testbench.sv
